[hdl/sit_pkg.sv]
// Shared types, codes and defaults for the session identity table.
package sit_pkg;

  localparam int TABLE_ENTRIES_DEF = 16;

  // Request codes
  localparam logic [1:0] REQ_REGISTER   = 2'd0;
  localparam logic [1:0] REQ_REMOVE     = 2'd1;
  localparam logic [1:0] REQ_DISCONNECT = 2'd2;

  // Result status codes
  localparam logic [3:0] ST_ACCEPTED         = 4'd0;
  localparam logic [3:0] ST_IDEMPOTENT       = 4'd1;
  localparam logic [3:0] ST_ACCOUNT_CONFLICT = 4'd2;
  localparam logic [3:0] ST_REPLAY           = 4'd3;
  localparam logic [3:0] ST_DUP_IDENTITY     = 4'd4;
  localparam logic [3:0] ST_FULL             = 4'd5;
  localparam logic [3:0] ST_REMOVED          = 4'd6;
  localparam logic [3:0] ST_ABSENT           = 4'd7;
  localparam logic [3:0] ST_MISMATCH         = 4'd8;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] account_id;
    logic [63:0] user_identity;
    logic [63:0] ticket_fingerprint;
    logic [31:0] ticket_kind;
  } sit_in_t;

  typedef struct packed {
    logic [3:0]  status;
    logic [63:0] stored_identity;
    logic        stored_identity_valid;
  } sit_out_t;

  typedef struct packed {
    logic        valid;
    logic [31:0] account;
    logic [63:0] identity;
    logic [63:0] fingerprint;
    logic [31:0] kind;
  } sit_entry_t;

  localparam int ENTRY_W = $bits(sit_entry_t);

  // Controller to datapath
  typedef struct packed {
    logic clr;     // write an empty entry at the walk index
    logic load;    // capture the request, restart the walk
    logic scan;    // read the entry at the walk index
    logic commit;  // apply the table update, load the result
  } sit_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic idx_last;  // walk index points at the last entry
    logic out_busy;  // result register holds an item that is not taken
  } sit_sts_t;

endpackage

[hdl/sit_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module sit_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                     wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[hdl/sit_datapath.sv]
// Datapath: request register, entry walk, match capture, update and result register.
module sit_datapath #(
  parameter int TABLE_ENTRIES = sit_pkg::TABLE_ENTRIES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  sit_pkg::sit_cmd_t  cmd,
  output sit_pkg::sit_sts_t  sts,
  input  sit_pkg::sit_in_t   in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output sit_pkg::sit_out_t  out_data
);

  localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam logic [AW-1:0] IDX_LAST = AW'(TABLE_ENTRIES - 1);

  sit_pkg::sit_in_t    req_r;
  logic [AW-1:0]       idx_r;
  logic [AW-1:0]       rd_idx_r;
  logic                rd_vld_r;

  logic                acct_hit_r;
  logic [AW-1:0]       acct_slot_r;
  logic [63:0]         acct_ident_r;
  logic                id_hit_r;
  logic [63:0]         id_fp_r;
  logic                free_hit_r;
  logic [AW-1:0]       free_slot_r;

  logic                out_valid_r;
  sit_pkg::sit_out_t   out_data_r;

  logic [sit_pkg::ENTRY_W-1:0] ram_rdata;
  logic [sit_pkg::ENTRY_W-1:0] ram_wdata;
  logic [AW-1:0]               ram_waddr;
  logic                        ram_we;
  sit_pkg::sit_entry_t         rd_entry;

  logic                dec_we;
  logic [AW-1:0]       dec_waddr;
  sit_pkg::sit_entry_t dec_wentry;
  sit_pkg::sit_out_t   dec_out;

  assign rd_entry = sit_pkg::sit_entry_t'(ram_rdata);

  // Walk index and read pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= cmd.scan;
      if (cmd.load) begin
        idx_r <= '0;
      end else if (cmd.clr || cmd.scan) begin
        idx_r <= (idx_r == IDX_LAST) ? '0 : idx_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r <= idx_r;
    if (cmd.load) begin
      req_r <= in_data;
    end
  end

  // Capture first account hit, first identity hit and lowest free slot
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acct_hit_r <= 1'b0;
      id_hit_r   <= 1'b0;
      free_hit_r <= 1'b0;
    end else if (cmd.load) begin
      acct_hit_r <= 1'b0;
      id_hit_r   <= 1'b0;
      free_hit_r <= 1'b0;
    end else if (rd_vld_r) begin
      if (rd_entry.valid && !acct_hit_r && rd_entry.account == req_r.account_id) begin
        acct_hit_r <= 1'b1;
      end
      if (rd_entry.valid && !id_hit_r && rd_entry.identity == req_r.user_identity) begin
        id_hit_r <= 1'b1;
      end
      if (!rd_entry.valid && !free_hit_r) begin
        free_hit_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_vld_r) begin
      if (rd_entry.valid && !acct_hit_r && rd_entry.account == req_r.account_id) begin
        acct_slot_r  <= rd_idx_r;
        acct_ident_r <= rd_entry.identity;
      end
      if (rd_entry.valid && !id_hit_r && rd_entry.identity == req_r.user_identity) begin
        id_fp_r <= rd_entry.fingerprint;
      end
      if (!rd_entry.valid && !free_hit_r) begin
        free_slot_r <= rd_idx_r;
      end
    end
  end

  // Decide the result and the table update from the finished walk
  always_comb begin
    dec_we                        = 1'b0;
    dec_waddr                     = acct_slot_r;
    dec_wentry.valid              = 1'b0;
    dec_wentry.account            = req_r.account_id;
    dec_wentry.identity           = req_r.user_identity;
    dec_wentry.fingerprint        = req_r.ticket_fingerprint;
    dec_wentry.kind               = req_r.ticket_kind;
    dec_out.status                = sit_pkg::ST_ABSENT;
    dec_out.stored_identity       = '0;
    dec_out.stored_identity_valid = 1'b0;
    case (req_r.req_type)
      sit_pkg::REQ_REGISTER: begin
        if (acct_hit_r) begin
          dec_out.status = (acct_ident_r == req_r.user_identity) ?
                           sit_pkg::ST_IDEMPOTENT : sit_pkg::ST_ACCOUNT_CONFLICT;
        end else if (id_hit_r) begin
          dec_out.status = (req_r.ticket_fingerprint != '0 &&
                            id_fp_r == req_r.ticket_fingerprint) ?
                           sit_pkg::ST_REPLAY : sit_pkg::ST_DUP_IDENTITY;
        end else if (free_hit_r) begin
          dec_we           = 1'b1;
          dec_waddr        = free_slot_r;
          dec_wentry.valid = 1'b1;
          dec_out.status   = sit_pkg::ST_ACCEPTED;
        end else begin
          dec_out.status = sit_pkg::ST_FULL;
        end
      end
      sit_pkg::REQ_REMOVE: begin
        if (acct_hit_r) begin
          dec_we         = 1'b1;
          dec_out.status = sit_pkg::ST_REMOVED;
        end
      end
      sit_pkg::REQ_DISCONNECT: begin
        if (acct_hit_r) begin
          dec_out.stored_identity       = acct_ident_r;
          dec_out.stored_identity_valid = 1'b1;
          if (acct_ident_r == req_r.user_identity) begin
            dec_we         = 1'b1;
            dec_out.status = sit_pkg::ST_REMOVED;
          end else begin
            dec_out.status = sit_pkg::ST_MISMATCH;
          end
        end
      end
      default: begin
        dec_out.status = sit_pkg::ST_ABSENT;
      end
    endcase
  end

  assign ram_we    = cmd.clr || (cmd.commit && dec_we);
  assign ram_waddr = cmd.clr ? idx_r : dec_waddr;
  assign ram_wdata = cmd.clr ? '0 : sit_pkg::ENTRY_W'(dec_wentry);

  sit_ram #(
    .WIDTH (sit_pkg::ENTRY_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (idx_r),
    .rdata (ram_rdata)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_data_r <= dec_out;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_data     = out_data_r;
  assign sts.idx_last = (idx_r == IDX_LAST);
  assign sts.out_busy = out_valid_r && out_stall;

endmodule

[hdl/sit_ctrl.sv]
// Controller: clearing pass after reset, then request accept, entry walk and commit.
module sit_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  sit_pkg::sit_sts_t sts,
  output sit_pkg::sit_cmd_t cmd
);

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_LAST   = 3'd3;
  localparam logic [2:0] S_COMMIT = 3'd4;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    in_stall   = 1'b1;
    case (state_r)
      S_CLEAR: begin
        cmd.clr = 1'b1;
        if (sts.idx_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.idx_last) begin
          state_nxt = S_LAST;
        end
      end
      S_LAST: begin
        // last entry's read data is compared this cycle
        state_nxt = S_COMMIT;
      end
      S_COMMIT: begin
        // hold until the result register is free
        if (!sts.out_busy) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

[hdl/session_identity_table_unit.sv]
// Top level of the session identity table: controller plus datapath.
//
// Bounded session table of TABLE_ENTRIES entries keyed by account id, held in
// one RAM. After reset the block runs a clearing pass over the table (in_stall
// high) that marks every entry empty. Each request then walks the whole table,
// one entry per cycle through the RAM's single read port, compares the last
// entry's read data and commits its result to the output register once that
// register is free. One request is in progress at a time; a finished result
// waits in the output register while the next request is accepted and walked.
module session_identity_table_unit #(
  parameter int TABLE_ENTRIES = sit_pkg::TABLE_ENTRIES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  sit_pkg::sit_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output sit_pkg::sit_out_t out_data
);

  sit_pkg::sit_cmd_t cmd;
  sit_pkg::sit_sts_t sts;

  sit_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  sit_datapath #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

[hdl/sit_checker.sv]
// Port-level checks for the session identity table, bound to the top level.
module sit_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input sit_pkg::sit_out_t out_data
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed or dropped");

  // one request at a time: accept is followed by a busy cycle
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("request accepted while previous one in progress");

  // stored identity is reported only by a disconnect of a present account
  a_ident_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.stored_identity_valid |->
      (out_data.status == sit_pkg::ST_REMOVED || out_data.status == sit_pkg::ST_MISMATCH))
    else $error("stored identity flagged with wrong status");

  a_ident_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.stored_identity_valid |-> out_data.stored_identity == '0)
    else $error("stored identity nonzero without valid flag");

endmodule

bind session_identity_table_unit sit_checker u_sit_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
